// ----- hdl/ssort_pkg.sv -----
package ssort_pkg;

  // Request codes
  localparam logic [1:0] REQ_PUSH  = 2'd0;
  localparam logic [1:0] REQ_SORT  = 2'd1;
  localparam logic [1:0] REQ_FETCH = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_WORD_FULL = 2'd1;
  localparam logic [1:0] ST_LIST_FULL = 2'd2;
  localparam logic [1:0] ST_EMPTY     = 2'd3;

  localparam logic [7:0] NEWLINE = 8'd10;

  typedef struct packed {
    logic push;        // handle a push request, emit its result
    logic emit_nf;     // emit "nothing to fetch"
    logic emit_nop;    // emit an all-zero result
    logic sort_open;   // close the open word, rewind, start the sort
    logic pass_start;  // j = 0
    logic pass_next;   // pass = pass + 1
    logic ord_rd;      // read order entries j and j+1
    logic cmp_load;    // latch the two word indexes, read lengths and first bytes
    logic cmp_step;    // advance to the next byte pair
    logic swap1;       // write order entry j
    logic swap2;       // write order entry j+1
    logic j_next;      // j = j + 1
    logic emit_sort;   // emit the sort result
    logic fetch_rd;    // read the order entry of the read pointer
    logic fetch_ld;    // read length and byte of the current word
    logic fetch_emit;  // emit the fetched byte and advance the read pointers
  } ssort_cmd_t;

  typedef struct packed {
    logic out_free;
    logic fetch_ok;
    logic pass_more;
    logic j_more;
    logic cmp_end;
    logic swap;
  } ssort_sts_t;

endpackage

// ----- hdl/string_bubble_sort.sv -----
// Word sorter. Push requests (one byte per word on the input, byte 10 ends a
// word) store up to MAX_WORDS words of up to MAX_WORD_LEN bytes. A sort
// request closes an open word and bubble-sorts an index table over the
// stored words; the comparator reads one byte of each word per cycle. A
// fetch returns one byte of the sorted text through a chain of registered
// reads of index table, length table and byte store. Each request gives
// exactly one result word; status reports dropped bytes or words and
// fetches past the end or before a sort. No clearing pass follows reset.
module string_bubble_sort import ssort_pkg::*; #(
  parameter int MAX_WORDS    = 64,
  parameter int MAX_WORD_LEN = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_req_type,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_last_of_list,
  output logic [1:0] out_status
);

  ssort_cmd_t cmd;
  ssort_sts_t sts;

  ssort_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_req_type (in_req_type),
    .in_stall    (in_stall),
    .sts         (sts),
    .cmd         (cmd)
  );

  ssort_dp #(
    .MAX_WORDS    (MAX_WORDS),
    .MAX_WORD_LEN (MAX_WORD_LEN)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_byte          (in_byte),
    .cmd              (cmd),
    .sts              (sts),
    .out_stall        (out_stall),
    .out_valid        (out_valid),
    .out_byte         (out_byte),
    .out_last_of_list (out_last_of_list),
    .out_status       (out_status)
  );

endmodule

// ----- hdl/ssort_ctrl.sv -----
module ssort_ctrl import ssort_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [1:0] in_req_type,
  output logic       in_stall,
  input  ssort_sts_t sts,
  output ssort_cmd_t cmd
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_PASS = 4'd1;
  localparam logic [3:0] S_JCHK = 4'd2;
  localparam logic [3:0] S_ORDW = 4'd3;
  localparam logic [3:0] S_CMP  = 4'd4;
  localparam logic [3:0] S_SW1  = 4'd5;
  localparam logic [3:0] S_SW2  = 4'd6;
  localparam logic [3:0] S_DONE = 4'd7;
  localparam logic [3:0] S_F1   = 4'd8;
  localparam logic [3:0] S_F2   = 4'd9;

  logic [3:0] state_r, state_nxt;
  logic       accept;

  assign in_stall = !((state_r == S_IDLE) && sts.out_free);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_req_type)
            REQ_PUSH: cmd.push = 1'b1;
            REQ_SORT: begin
              cmd.sort_open = 1'b1;
              state_nxt     = S_PASS;
            end
            REQ_FETCH: begin
              if (sts.fetch_ok) begin
                cmd.fetch_rd = 1'b1;
                state_nxt    = S_F1;
              end else begin
                cmd.emit_nf = 1'b1;
              end
            end
            default: cmd.emit_nop = 1'b1;
          endcase
        end
      end
      S_PASS: begin
        if (sts.pass_more) begin
          cmd.pass_start = 1'b1;
          state_nxt      = S_JCHK;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_JCHK: begin
        if (sts.j_more) begin
          cmd.ord_rd = 1'b1;
          state_nxt  = S_ORDW;
        end else begin
          cmd.pass_next = 1'b1;
          state_nxt     = S_PASS;
        end
      end
      S_ORDW: begin
        cmd.cmp_load = 1'b1;
        state_nxt    = S_CMP;
      end
      S_CMP: begin
        if (!sts.cmp_end) begin
          cmd.cmp_step = 1'b1;
        end else if (sts.swap) begin
          state_nxt = S_SW1;
        end else begin
          cmd.j_next = 1'b1;
          state_nxt  = S_JCHK;
        end
      end
      S_SW1: begin
        cmd.swap1 = 1'b1;
        state_nxt = S_SW2;
      end
      S_SW2: begin
        cmd.swap2  = 1'b1;
        cmd.j_next = 1'b1;
        state_nxt  = S_JCHK;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.emit_sort = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_F1: begin
        cmd.fetch_ld = 1'b1;
        state_nxt    = S_F2;
      end
      S_F2: begin
        if (sts.out_free) begin
          cmd.fetch_emit = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // A swap always writes both order entries back to back.
  a_swap_pair: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.swap1 |=> cmd.swap2)
    else $error("swap not completed");

  // The byte compare only runs after the operands were loaded.
  a_cmp_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CMP) |-> ($past(state_r) == S_ORDW || $past(state_r) == S_CMP))
    else $error("compare entered without operands");

  // A new word is taken only while no other request is in flight.
  a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> (state_r == S_IDLE))
    else $error("word accepted while busy");

endmodule

// ----- hdl/ssort_dp.sv -----
module ssort_dp import ssort_pkg::*; #(
  parameter int MAX_WORDS    = 64,
  parameter int MAX_WORD_LEN = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic [7:0] in_byte,
  input  ssort_cmd_t cmd,
  output ssort_sts_t sts,
  input  logic       out_stall,
  output logic       out_valid,
  output logic [7:0] out_byte,
  output logic       out_last_of_list,
  output logic [1:0] out_status
);

  localparam int WW    = $clog2(MAX_WORDS);
  localparam int CW    = $clog2(MAX_WORDS + 1);
  localparam int LW    = $clog2(MAX_WORD_LEN + 1);
  localparam int DEPTH = MAX_WORDS * MAX_WORD_LEN;
  localparam int AW    = $clog2(DEPTH);
  localparam logic [CW-1:0] MAXW = CW'(MAX_WORDS);
  localparam logic [LW-1:0] MAXL = LW'(MAX_WORD_LEN);

  logic [WW-1:0] ord_mem [MAX_WORDS];
  logic [LW-1:0] len_mem [MAX_WORDS];
  logic [7:0]    str_mem [DEPTH];

  logic [CW-1:0] wcnt_r, wcnt_nxt, rwp_r, rwp_nxt, pass_r, pass_nxt, j_r, j_nxt;
  logic [LW-1:0] olen_r, olen_nxt, rbp_r, rbp_nxt, i_r, i_nxt;
  logic          sorted_r, sorted_nxt;
  logic [WW-1:0] oa_r, oa_nxt, ob_r, ob_nxt;
  logic [1:0]    stat_r, stat_nxt;
  logic          out_valid_r, out_valid_nxt, last_r, last_nxt;
  logic [7:0]    obyte_r, obyte_nxt;
  logic [1:0]    ostat_r, ostat_nxt;

  logic [WW-1:0] ordq_a_r, ordq_b_r;
  logic [LW-1:0] lenq_a_r, lenq_b_r;
  logic [7:0]    strq_a_r, strq_b_r;

  function automatic logic [AW-1:0] st_addr(input logic [WW-1:0] w, input logic [LW-1:0] b);
    return AW'(w) * AW'(MAX_WORD_LEN) + AW'(b);
  endfunction

  function automatic logic [LW-1:0] clampb(input logic [LW-1:0] b);
    return (b < MAXL) ? b : '0;
  endfunction

  // Push bookkeeping; a push after a sort sees an empty list.
  logic [CW-1:0] ewc;
  logic [LW-1:0] eol;
  logic          is_nl, has_room, sc_room, sc_need;
  logic [1:0]    push_st;
  logic [LW-1:0] n_min;
  logic          in_rng, f_inword;

  assign ewc      = sorted_r ? '0 : wcnt_r;
  assign eol      = sorted_r ? '0 : olen_r;
  assign is_nl    = (in_byte == NEWLINE);
  assign has_room = (ewc < MAXW);
  assign sc_need  = (olen_r != '0);
  assign sc_room  = (wcnt_r < MAXW);

  always_comb begin
    if (is_nl)          push_st = has_room ? ST_OK : ST_LIST_FULL;
    else if (!has_room) push_st = ST_LIST_FULL;
    else if (eol >= MAXL) push_st = ST_WORD_FULL;
    else                push_st = ST_OK;
  end

  assign n_min    = (lenq_a_r < lenq_b_r) ? lenq_a_r : lenq_b_r;
  assign in_rng   = (i_r < n_min);
  assign f_inword = (rbp_r < lenq_a_r);

  assign sts.out_free  = !out_valid_r || !out_stall;
  assign sts.fetch_ok  = sorted_r && (rwp_r < wcnt_r);
  assign sts.pass_more = ({1'b0, pass_r} + 1'b1) < {1'b0, wcnt_r};
  assign sts.j_more    = ({1'b0, j_r} + 1'b1) < {1'b0, wcnt_r - pass_r};
  assign sts.cmp_end   = !in_rng || (strq_a_r != strq_b_r);
  assign sts.swap      = in_rng ? (strq_a_r > strq_b_r) : (lenq_a_r > lenq_b_r);

  always_comb begin
    wcnt_nxt = wcnt_r; olen_nxt = olen_r; rwp_nxt = rwp_r; rbp_nxt = rbp_r;
    sorted_nxt = sorted_r; pass_nxt = pass_r; j_nxt = j_r; i_nxt = i_r;
    oa_nxt = oa_r; ob_nxt = ob_r; stat_nxt = stat_r;
    out_valid_nxt = out_valid_r && out_stall;
    obyte_nxt = obyte_r; last_nxt = last_r; ostat_nxt = ostat_r;

    if (cmd.push) begin
      sorted_nxt = 1'b0;
      rwp_nxt    = '0;
      rbp_nxt    = '0;
      wcnt_nxt   = ewc;
      olen_nxt   = eol;
      if (is_nl) begin
        olen_nxt = '0;
        if (has_room) wcnt_nxt = ewc + 1'b1;
      end else if (push_st == ST_OK) begin
        olen_nxt = eol + 1'b1;
      end
      out_valid_nxt = 1'b1; obyte_nxt = '0; last_nxt = 1'b0; ostat_nxt = push_st;
    end
    if (cmd.emit_nf || cmd.emit_nop) begin
      out_valid_nxt = 1'b1; obyte_nxt = '0; last_nxt = 1'b0;
      ostat_nxt = cmd.emit_nf ? ST_EMPTY : ST_OK;
    end
    if (cmd.sort_open) begin
      stat_nxt = ST_OK;
      if (sc_need) begin
        olen_nxt = '0;
        if (sc_room) wcnt_nxt = wcnt_r + 1'b1;
        else         stat_nxt = ST_LIST_FULL;
      end
      sorted_nxt = 1'b1;
      rwp_nxt    = '0;
      rbp_nxt    = '0;
      pass_nxt   = '0;
    end
    if (cmd.pass_start) j_nxt = '0;
    if (cmd.pass_next)  pass_nxt = pass_r + 1'b1;
    if (cmd.j_next)     j_nxt = j_r + 1'b1;
    if (cmd.cmp_load) begin
      i_nxt  = '0;
      oa_nxt = ordq_a_r;
      ob_nxt = ordq_b_r;
    end
    if (cmd.cmp_step) i_nxt = i_r + 1'b1;
    if (cmd.emit_sort) begin
      out_valid_nxt = 1'b1; obyte_nxt = '0; last_nxt = 1'b0; ostat_nxt = stat_r;
    end
    if (cmd.fetch_emit) begin
      out_valid_nxt = 1'b1;
      ostat_nxt     = ST_OK;
      if (f_inword) begin
        obyte_nxt = strq_a_r;
        last_nxt  = 1'b0;
        rbp_nxt   = rbp_r + 1'b1;
      end else begin
        obyte_nxt = NEWLINE;
        last_nxt  = ((rwp_r + 1'b1) == wcnt_r);
        rwp_nxt   = rwp_r + 1'b1;
        rbp_nxt   = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wcnt_r <= '0; olen_r <= '0; rwp_r <= '0; rbp_r <= '0;
      sorted_r <= 1'b0; out_valid_r <= 1'b0;
    end else begin
      wcnt_r <= wcnt_nxt; olen_r <= olen_nxt; rwp_r <= rwp_nxt; rbp_r <= rbp_nxt;
      sorted_r <= sorted_nxt; out_valid_r <= out_valid_nxt;
    end
    pass_r <= pass_nxt; j_r <= j_nxt; i_r <= i_nxt; oa_r <= oa_nxt; ob_r <= ob_nxt;
    stat_r <= stat_nxt; obyte_r <= obyte_nxt; last_r <= last_nxt; ostat_r <= ostat_nxt;
  end

  // Order table: a permutation of word slots, identity as words are closed.
  logic          ord_we;
  logic [WW-1:0] ord_wa, ord_wd;
  always_comb begin
    ord_we = 1'b0; ord_wa = '0; ord_wd = '0;
    if (cmd.push && is_nl && has_room) begin
      ord_we = 1'b1; ord_wa = WW'(ewc); ord_wd = WW'(ewc);
    end else if (cmd.sort_open && sc_need && sc_room) begin
      ord_we = 1'b1; ord_wa = WW'(wcnt_r); ord_wd = WW'(wcnt_r);
    end else if (cmd.swap1) begin
      ord_we = 1'b1; ord_wa = WW'(j_r); ord_wd = ob_r;
    end else if (cmd.swap2) begin
      ord_we = 1'b1; ord_wa = WW'(j_r + 1'b1); ord_wd = oa_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ord_we) ord_mem[ord_wa] <= ord_wd;
    if (cmd.ord_rd || cmd.fetch_rd) begin
      ordq_a_r <= ord_mem[cmd.fetch_rd ? WW'(rwp_r) : WW'(j_r)];
      ordq_b_r <= ord_mem[WW'(j_r + 1'b1)];
    end
  end

  // Word lengths
  always_ff @(posedge clk) begin
    if (cmd.push && is_nl && has_room) len_mem[WW'(ewc)] <= eol;
    else if (cmd.sort_open && sc_need && sc_room) len_mem[WW'(wcnt_r)] <= olen_r;
    if (cmd.cmp_load || cmd.fetch_ld) begin
      lenq_a_r <= len_mem[ordq_a_r];
      lenq_b_r <= len_mem[ordq_b_r];
    end
  end

  // Word bytes
  logic [AW-1:0] rda, rdb;
  always_comb begin
    if (cmd.cmp_step) begin
      rda = st_addr(oa_r, clampb(i_r + 1'b1));
      rdb = st_addr(ob_r, clampb(i_r + 1'b1));
    end else if (cmd.fetch_ld) begin
      rda = st_addr(ordq_a_r, clampb(rbp_r));
      rdb = st_addr(ordq_b_r, '0);
    end else begin
      rda = st_addr(ordq_a_r, '0);
      rdb = st_addr(ordq_b_r, '0);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push && !is_nl && (push_st == ST_OK)) str_mem[st_addr(WW'(ewc), eol)] <= in_byte;
    if (cmd.cmp_load || cmd.cmp_step || cmd.fetch_ld) begin
      strq_a_r <= str_mem[rda];
      strq_b_r <= str_mem[rdb];
    end
  end

  assign out_valid        = out_valid_r;
  assign out_byte         = obyte_r;
  assign out_last_of_list = last_r;
  assign out_status       = ostat_r;

  a_wcnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    wcnt_r <= MAXW)
    else $error("word count over capacity");

  a_olen_bound: assert property (@(posedge clk) disable iff (!rst_n)
    olen_r <= MAXL)
    else $error("open word over length limit");

  a_read_rewound: assert property (@(posedge clk) disable iff (!rst_n)
    !sorted_r |-> (rwp_r == '0 && rbp_r == '0))
    else $error("read pointers moved on an unsorted list");

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
module testbench;
  import ssort_pkg::*;

  localparam int NWORDS = 64;
  localparam int WLEN   = 32;

  typedef struct packed {
    logic [7:0] obyte;
    logic       last;
    logic [1:0] status;
  } sorter_result_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [1:0] in_req_type = REQ_PUSH;
  logic [7:0] in_byte = 8'd0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_byte;
  logic       out_last_of_list;
  logic [1:0] out_status;

  // Predictor state.
  logic [7:0] text_mem[NWORDS][WLEN];
  int         text_len[NWORDS];
  int         n_words, open_len, rd_word, rd_byte;
  bit         is_sorted;

  sorter_result_t results_due[$];
  int  fail_count = 0;
  int  send_idle_pct = 23;
  int  recv_idle_pct = 23;
  bit  hold_recv = 1'b0;

  string_bubble_sort i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_req_type(in_req_type), .in_byte(in_byte),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_byte(out_byte), .out_last_of_list(out_last_of_list),
    .out_status(out_status)
  );

  always #1 clk = ~clk;

  function automatic bit word_after(int a, int b);
    int n;
    n = (text_len[a] < text_len[b]) ? text_len[a] : text_len[b];
    for (int i = 0; i < n; i++)
      if (text_mem[a][i] != text_mem[b][i]) return text_mem[a][i] > text_mem[b][i];
    return text_len[a] > text_len[b];
  endfunction

  function automatic logic [1:0] close_open_word();
    logic [1:0] st;
    st = ST_OK;
    if (n_words < NWORDS) begin
      text_len[n_words] = open_len;
      n_words++;
    end else begin
      st = ST_LIST_FULL;
    end
    open_len = 0;
    return st;
  endfunction

  function automatic sorter_result_t predict_sorter(logic [1:0] req, logic [7:0] b);
    sorter_result_t r;
    logic [7:0] tw[WLEN];
    int tl;
    r = '0;
    if (req == REQ_PUSH) begin
      if (is_sorted) begin
        n_words = 0; open_len = 0; rd_word = 0; rd_byte = 0; is_sorted = 0;
      end
      if (b == NEWLINE) r.status = close_open_word();
      else if (n_words >= NWORDS) r.status = ST_LIST_FULL;
      else if (open_len >= WLEN) r.status = ST_WORD_FULL;
      else begin
        text_mem[n_words][open_len] = b;
        open_len++;
      end
    end else if (req == REQ_SORT) begin
      if (open_len > 0) r.status = close_open_word();
      for (int p = 0; p + 1 < n_words; p++)
        for (int j = 0; j + 1 < n_words - p; j++)
          if (word_after(j, j + 1)) begin
            tw = text_mem[j]; text_mem[j] = text_mem[j+1]; text_mem[j+1] = tw;
            tl = text_len[j]; text_len[j] = text_len[j+1]; text_len[j+1] = tl;
          end
      is_sorted = 1; rd_word = 0; rd_byte = 0;
    end else if (req == REQ_FETCH) begin
      if (!is_sorted || rd_word >= n_words) r.status = ST_EMPTY;
      else if (rd_byte < text_len[rd_word]) begin
        r.obyte = text_mem[rd_word][rd_byte];
        rd_byte++;
      end else begin
        r.obyte = NEWLINE;
        rd_word++;
        rd_byte = 0;
        r.last = (rd_word == n_words);
      end
    end
    return r;
  endfunction

  // Valid stays high after an accepted word; the next call may lower it, drain() does.
  task automatic send_word(logic [1:0] req, logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_req_type <= req;
    in_byte     <= b;
    results_due.push_back(predict_sorter(req, b));
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
  endtask

  task automatic push_text(string s);
    for (int i = 0; i < s.len(); i++) send_word(REQ_PUSH, s[i]);
  endtask

  task automatic fetch_n(int n);
    for (int i = 0; i < n; i++) send_word(REQ_FETCH, 8'd0);
  endtask

  always @(posedge clk) begin
    sorter_result_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (results_due.size() == 0) begin
        $error("unexpected result word");
        fail_count++;
      end else begin
        e = results_due.pop_front();
        if (out_byte !== e.obyte) begin
          $error("out_byte: expected %0d, got %0d", e.obyte, out_byte);
          fail_count++;
        end
        if (out_last_of_list !== e.last) begin
          $error("out_last_of_list: expected %0d, got %0d", e.last, out_last_of_list);
          fail_count++;
        end
        if (out_status !== e.status) begin
          $error("out_status: expected %0d, got %0d", e.status, out_status);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (hold_recv) out_stall <= 1'b1;
    else out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  task automatic test_directed();
    fetch_n(2);
    send_word(2'd3, 8'hFF);
    push_text("b\na\n\n");
    send_word(REQ_PUSH, 8'hFF);
    send_word(REQ_PUSH, 8'h00);
    push_text("ab");
    send_word(REQ_SORT, 8'd0);
    send_word(REQ_SORT, 8'd0);
    fetch_n(12);
    // Over-long word: the tail bytes are dropped.
    for (int i = 0; i < WLEN + 3; i++) send_word(REQ_PUSH, 8'h41 + i[3:0]);
    send_word(REQ_PUSH, NEWLINE);
    send_word(REQ_SORT, 8'd0);
    fetch_n(WLEN + 3);
    drain();
  endtask

  task automatic test_list_full();
    for (int i = 0; i < NWORDS + 2; i++) begin
      send_word(REQ_PUSH, 8'($urandom_range(255)) & 8'hF7 | 8'h01);
      send_word(REQ_PUSH, NEWLINE);
    end
    send_word(REQ_PUSH, 8'h5A);
    send_word(REQ_SORT, 8'd0);
    fetch_n(3 * NWORDS + 2);
    drain();
  endtask

  task automatic test_backpressure();
    fork
      begin
        hold_recv = 1'b1;
        repeat (300) @(posedge clk);
        hold_recv = 1'b0;
      end
      begin
        push_text("zz\nyy\nxx\n");
        send_word(REQ_SORT, 8'd0);
        fetch_n(12);
      end
    join
    drain();
  endtask

  task automatic test_random(int n_items);
    int sent, nw, len;
    logic [7:0] b;
    sent = 0;
    while (sent < n_items) begin
      if (sent > n_items / 2 && sent < n_items / 2 + 200) begin
        send_idle_pct = 0; recv_idle_pct = 0;
      end else begin
        send_idle_pct = 23; recv_idle_pct = 23;
      end
      nw = $urandom_range(12);
      for (int w = 0; w < nw; w++) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(WLEN + 2) : $urandom_range(4);
        for (int k = 0; k < len; k++) begin
          b = $urandom_range(3) == 0 ? 8'($urandom_range(255)) :
                                       8'(8'h61 + $urandom_range(2));
          if (b == NEWLINE) b = 8'h00;
          send_word(REQ_PUSH, b);
        end
        if ($urandom_range(9) != 0 || w + 1 < nw) send_word(REQ_PUSH, NEWLINE);
        sent += len + 1;
      end
      if ($urandom_range(9) == 0) send_word(2'($urandom_range(3)), 8'($urandom_range(255)));
      send_word(REQ_SORT, 8'd0);
      len = $urandom_range(60);
      fetch_n(len);
      sent += len + 1;
      if ($urandom_range(7) == 0) drain();
    end
    drain();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_list_full();
    test_backpressure();
    test_random(1150);
    repeat (50) @(posedge clk);
    if (fail_count == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

  initial begin
    #20ms;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/ssort_pkg.sv
hdl/ssort_ctrl.sv
hdl/ssort_dp.sv
hdl/string_bubble_sort.sv
sim/testbench.sv
